[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers for the node table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every edge outside reset
`define RNT_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expr must never be true outside reset
`define RNT_NEVER(name, clk, rst_n, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[rtl/rnt_pkg.sv]
// ----------------------------------------------------------------------------
// rnt_pkg
// Types, codes and sizes for the node48 child table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rnt_pkg;

  localparam int SLOTS_DEF       = 48;
  localparam int CHILD_WIDTH_DEF = 32;
  localparam int KEYS            = 256;
  localparam int KEY_W           = 8;
  localparam int CHILD_W         = 32;
  localparam int COUNT_W         = 6;
  localparam int QUEUE_DEPTH     = 2;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_PUT     = 2'd0;
  localparam mode_t MODE_LOCATE  = 2'd1;
  localparam mode_t MODE_REPLACE = 2'd2;
  localparam mode_t MODE_SCAN    = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_FULL      = 2'd2;
  localparam status_t ST_EMPTY     = 2'd3;

  // classified operation handed from front to back
  typedef logic [2:0] op_t;
  localparam op_t OP_PUT        = 3'd0;
  localparam op_t OP_LOCATE     = 3'd1;
  localparam op_t OP_REPLACE    = 3'd2;
  localparam op_t OP_SCAN       = 3'd3;
  localparam op_t OP_SCAN_EMPTY = 3'd4;

  typedef struct packed {
    mode_t              mode;
    logic [KEY_W-1:0]   key;
    logic [KEY_W-1:0]   high_key;
    logic [CHILD_W-1:0] child_value;
  } in_word_t;

  typedef struct packed {
    status_t            status;
    logic [KEY_W-1:0]   key_out;
    logic [CHILD_W-1:0] child_out;
    logic [COUNT_W-1:0] child_count;
    logic               is_full;
    logic               last;
  } out_word_t;

  typedef struct packed {
    op_t                op;
    logic [KEY_W-1:0]   key;
    logic [KEY_W-1:0]   high_key;
    logic [CHILD_W-1:0] child;
  } cmd_t;

endpackage

[rtl/rnt_stream_if.sv]
// ----------------------------------------------------------------------------
// rnt_stream_if
// Valid/ready channel carrying one word of a chosen payload type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rnt_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/rnt_front.sv]
// ----------------------------------------------------------------------------
// rnt_front
// Accepts input words, classifies them into commands, holds one in a register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rnt_front (
  input  logic         clk,
  input  logic         rst_n,
  rnt_stream_if.sink   in_ch,
  rnt_stream_if.source cmd_ch
);

  logic          hold_v_r;
  rnt_pkg::cmd_t hold_r;
  rnt_pkg::cmd_t cls;
  logic          take;

  always_comb begin
    cls.key      = in_ch.data.key;
    cls.high_key = in_ch.data.high_key;
    cls.child    = in_ch.data.child_value;
    case (in_ch.data.mode)
      rnt_pkg::MODE_PUT:     cls.op = rnt_pkg::OP_PUT;
      rnt_pkg::MODE_LOCATE:  cls.op = rnt_pkg::OP_LOCATE;
      rnt_pkg::MODE_REPLACE: cls.op = rnt_pkg::OP_REPLACE;
      rnt_pkg::MODE_SCAN: begin
        // inverted bounds give an empty scan without walking the index
        cls.op = (in_ch.data.key > in_ch.data.high_key) ?
                 rnt_pkg::OP_SCAN_EMPTY : rnt_pkg::OP_SCAN;
      end
      default:               cls.op = rnt_pkg::OP_LOCATE;
    endcase
  end

  assign in_ch.ready  = !hold_v_r || cmd_ch.ready;
  assign take         = in_ch.valid && in_ch.ready;
  assign cmd_ch.valid = hold_v_r;
  assign cmd_ch.data  = hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      hold_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_r <= cls;
    end
  end

endmodule

[rtl/rnt_queue.sv]
// ----------------------------------------------------------------------------
// rnt_queue
// Short command FIFO between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rnt_queue (
  input  logic         clk,
  input  logic         rst_n,
  rnt_stream_if.sink   up_ch,
  rnt_stream_if.source dn_ch
);

  localparam int DEPTH = rnt_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  rnt_pkg::cmd_t   entry_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            push;
  logic            pop;

  assign up_ch.ready = (cnt_r != CW'(DEPTH));
  assign dn_ch.valid = (cnt_r != '0);
  assign dn_ch.data  = entry_r[rd_ptr_r];
  assign push        = up_ch.valid && up_ch.ready;
  assign pop         = dn_ch.valid && dn_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= up_ch.data;
    end
  end

endmodule

[rtl/rnt_back.sv]
// ----------------------------------------------------------------------------
// rnt_back
// Executes commands against the key index, the slot store and the count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rnt_back #(
  parameter int SLOTS       = rnt_pkg::SLOTS_DEF,
  parameter int CHILD_WIDTH = rnt_pkg::CHILD_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  rnt_stream_if.sink   cmd_ch,
  rnt_stream_if.source out_ch
);

  localparam int SIW  = $clog2(SLOTS);
  localparam int CNTW = $clog2(SLOTS + 1);
  localparam int SW   = (CHILD_WIDTH < rnt_pkg::CHILD_W) ? CHILD_WIDTH : rnt_pkg::CHILD_W;
  localparam int KW   = rnt_pkg::KEY_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_IDX  = 3'd1;
  localparam logic [2:0] S_SLOT = 3'd2;
  localparam logic [2:0] S_EXE  = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_SEND = 3'd5;

  logic [2:0]               state_r, state_nxt;
  rnt_pkg::cmd_t            cmd_r;
  logic [KW-1:0]            cur_r;
  logic                     kv_r;
  logic [SIW-1:0]           ks_rd_r;
  logic [SIW-1:0]           slot_r;
  logic [SW-1:0]            ch_rd_r;
  logic [CNTW-1:0]          count_r;
  logic [rnt_pkg::KEYS-1:0] key_valid_r;
  logic                     pend_v_r;
  logic [KW-1:0]            pend_key_r;
  logic [SW-1:0]            pend_child_r;
  logic                     out_v_r;
  rnt_pkg::out_word_t       out_r;

  // key index and slot store
  logic [SIW-1:0] key_slot_mem [rnt_pkg::KEYS];
  logic [SW-1:0]  slot_mem     [SLOTS];

  logic                 full;
  logic                 kv_cur;
  logic [SIW-1:0]       free_slot;
  logic [SIW-1:0]       slot_sel;
  logic                 out_free;
  logic                 at_low;
  logic [SW-1:0]        new_child;
  logic [CNTW-1:0]      count_after;
  logic                 pop;
  logic                 emit;
  logic                 map_new;
  logic                 ch_we;
  logic                 pend_load;
  logic                 pend_clr;
  logic                 cur_dec;
  rnt_pkg::out_word_t   ow;

  assign full        = (count_r >= CNTW'(SLOTS));
  assign kv_cur      = key_valid_r[cur_r];
  // slots are never freed, so the lowest free slot is the count
  assign free_slot   = full ? '0 : count_r[SIW-1:0];
  assign slot_sel    = kv_r ? ks_rd_r : free_slot;
  assign out_free    = !out_v_r || out_ch.ready;
  assign at_low      = (cur_r == cmd_r.key);
  assign new_child   = cmd_r.child[SW-1:0];
  assign count_after = map_new ? count_r + CNTW'(1) : count_r;

  assign cmd_ch.ready = (state_r == S_IDLE);
  assign pop          = cmd_ch.valid && cmd_ch.ready;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  always_comb begin
    state_nxt      = state_r;
    emit           = 1'b0;
    map_new        = 1'b0;
    ch_we          = 1'b0;
    pend_load      = 1'b0;
    pend_clr       = 1'b0;
    cur_dec        = 1'b0;
    ow.status      = rnt_pkg::ST_OK;
    ow.key_out     = cmd_r.key;
    ow.child_out   = '0;
    ow.last        = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (pop) begin
          case (cmd_ch.data.op)
            rnt_pkg::OP_SCAN:       state_nxt = S_SCAN;
            rnt_pkg::OP_SCAN_EMPTY: state_nxt = S_SEND;
            default:                state_nxt = S_IDX;
          endcase
        end
      end
      S_IDX: state_nxt = S_SLOT;
      S_SLOT: state_nxt = S_EXE;
      S_SCAN: begin
        if (kv_cur) begin
          state_nxt = S_SLOT;
        end else if (at_low) begin
          state_nxt = S_SEND;
        end else begin
          cur_dec = 1'b1;
        end
      end
      S_EXE: begin
        if (cmd_r.op == rnt_pkg::OP_SCAN) begin
          // the previous hit goes out only once a later hit is known
          if (!pend_v_r || out_free) begin
            emit         = pend_v_r;
            ow.key_out   = pend_key_r;
            ow.child_out = rnt_pkg::CHILD_W'(pend_child_r);
            ow.last      = 1'b0;
            pend_load    = 1'b1;
            if (at_low) begin
              state_nxt = S_SEND;
            end else begin
              cur_dec   = 1'b1;
              state_nxt = S_SCAN;
            end
          end
        end else if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          case (cmd_r.op)
            rnt_pkg::OP_PUT: begin
              if (kv_r || !full) begin
                map_new      = !kv_r;
                ch_we        = 1'b1;
                ow.child_out = rnt_pkg::CHILD_W'(new_child);
              end else begin
                ow.status = rnt_pkg::ST_FULL;
              end
            end
            rnt_pkg::OP_REPLACE: begin
              if (kv_r) begin
                ch_we        = 1'b1;
                ow.child_out = rnt_pkg::CHILD_W'(new_child);
              end else begin
                ow.status = rnt_pkg::ST_NOT_FOUND;
              end
            end
            default: begin
              if (kv_r) begin
                ow.child_out = rnt_pkg::CHILD_W'(ch_rd_r);
              end else begin
                ow.status = rnt_pkg::ST_NOT_FOUND;
              end
            end
          endcase
        end
      end
      S_SEND: begin
        if (out_free) begin
          emit      = 1'b1;
          pend_clr  = 1'b1;
          state_nxt = S_IDLE;
          if (pend_v_r) begin
            ow.key_out   = pend_key_r;
            ow.child_out = rnt_pkg::CHILD_W'(pend_child_r);
          end else begin
            ow.status  = rnt_pkg::ST_EMPTY;
            ow.key_out = '0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    ow.child_count = rnt_pkg::COUNT_W'(count_after);
    ow.is_full     = (count_after >= CNTW'(SLOTS));
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      key_valid_r <= '0;
      pend_v_r    <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (map_new) begin
        count_r                <= count_after;
        key_valid_r[cmd_r.key] <= 1'b1;
      end
      if (pop || pend_clr) begin
        pend_v_r <= 1'b0;
      end else if (pend_load) begin
        pend_v_r <= 1'b1;
      end
      if (emit) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers and memories
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= cmd_ch.data;
      cur_r <= (cmd_ch.data.op == rnt_pkg::OP_SCAN) ? cmd_ch.data.high_key
                                                    : cmd_ch.data.key;
    end else if (cur_dec) begin
      cur_r <= cur_r - KW'(1);
    end
    if (state_r == S_IDX || state_r == S_SCAN) begin
      ks_rd_r <= key_slot_mem[cur_r];
      kv_r    <= kv_cur;
    end
    if (state_r == S_SLOT) begin
      slot_r  <= slot_sel;
      ch_rd_r <= slot_mem[slot_sel];
    end
    if (map_new) begin
      key_slot_mem[cmd_r.key] <= slot_r;
    end
    if (ch_we) begin
      slot_mem[slot_r] <= new_child;
    end
    if (pend_load) begin
      pend_key_r   <= cur_r;
      pend_child_r <= ch_rd_r;
    end
    if (emit) begin
      out_r <= ow;
    end
  end

  `RNT_ASSERT(a_count_bound, clk, rst_n, count_r <= CNTW'(SLOTS), "slot count above capacity")
  `RNT_ASSERT(a_map_grows, clk, rst_n, map_new |=> (count_r == $past(count_r) + CNTW'(1)), "new key did not raise the count")
  `RNT_NEVER(a_emit_room, clk, rst_n, emit && !out_free, "result word overwrote a waiting word")
  `RNT_ASSERT(a_cursor_range, clk, rst_n, (state_r == S_SCAN) |-> (cur_r >= cmd_r.key && cur_r <= cmd_r.high_key), "scan cursor left its range")

endmodule

[rtl/radix_node48_child_table.sv]
// ----------------------------------------------------------------------------
// radix_node48_child_table
// Node48 child table: key byte index over a small store of child slots.
// ----------------------------------------------------------------------------
// Input words arrive on in_ch (mode, key, high_key, child_value) and result
// words leave on out_ch (status, key_out, child_out, child_count, is_full,
// last), both valid/ready; a word moves when valid and ready are high.
// A front register classifies each word, a two-entry queue decouples it
// from the execution back end, and the back end owns an output register,
// so new words are taken while a result waits to be taken.
// Put, locate and replace step through pop, index read, slot read and
// execute in the back end.
// A scan walks the index from high_key down to key, one key per cycle
// while the keys are unmapped; each mapped key adds a slot read and an
// execute step, which waits for room at the output. Each hit is held
// back until the next is found so the final word can carry last.
// Reset clears the key valid bits, the count and all handshake state; no
// clearing pass is needed. A stalled receiver holds the back end in its
// execute or send step; the queue then fills and in_ch.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radix_node48_child_table #(
  parameter int SLOTS       = rnt_pkg::SLOTS_DEF,
  parameter int CHILD_WIDTH = rnt_pkg::CHILD_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  rnt_stream_if.sink   in_ch,
  rnt_stream_if.source out_ch
);

  rnt_stream_if #(.payload_t(rnt_pkg::cmd_t)) front_q ();
  rnt_stream_if #(.payload_t(rnt_pkg::cmd_t)) q_back ();

  rnt_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cmd_ch (front_q)
  );

  rnt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .up_ch (front_q),
    .dn_ch (q_back)
  );

  rnt_back #(
    .SLOTS       (SLOTS),
    .CHILD_WIDTH (CHILD_WIDTH)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd_ch (q_back),
    .out_ch (out_ch)
  );

endmodule
